// ----- hw/rtl/pll_pkg.sv -----
// pll_pkg: command codes, status codes, controller states and the
// packed command and response structs of the pooled linked list engine.
// No dependencies.
package pll_pkg;

    typedef enum logic [3:0] {
        OP_CREATE     = 4'd0,
        OP_COUNT      = 4'd1,
        OP_APPEND     = 4'd2,
        OP_PREPEND    = 4'd3,
        OP_FIRST      = 4'd4,
        OP_LAST       = 4'd5,
        OP_NEXT       = 4'd6,
        OP_PREV       = 4'd7,
        OP_CURR       = 4'd8,
        OP_INS_AFTER  = 4'd9,
        OP_INS_BEFORE = 4'd10,
        OP_REMOVE     = 4'd11,
        OP_TRIM       = 4'd12,
        OP_CONCAT     = 4'd13,
        OP_FREE       = 4'd14
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BOUNDS    = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_NULL_ITEM = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_INS1,
        S_INS2,
        S_INS3,
        S_STEP,
        S_TGT,
        S_ITEM,
        S_UNL1,
        S_UNL2,
        S_FREE,
        S_FIN
    } state_t;

    localparam logic BEFORE_START = 1'b0;
    localparam logic BEYOND_END   = 1'b1;

    typedef struct packed {
        logic [3:0]  op;
        logic [3:0]  list_id;
        logic [3:0]  second_list_id;
        logic [31:0] item_handle;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_item;
        logic [3:0]  new_list_id;
        logic [10:0] item_count;
    } rsp_t;

endpackage

// ----- hw/rtl/pooled_linked_list_engine.sv -----
// channel   | valid      | stall      | payload
// cmd       | cmd_valid  | cmd_stall  | cmd (pll_pkg::cmd_t)
// rsp       | rsp_valid  | rsp_stall  | rsp (pll_pkg::rsp_t)
//
// One command at a time; the states of each follow the dependent reads of the
// node store's one shared read address; free walks the list node by node.
// After reset the next links are chained into the free stack by a sweep over
// all NUM_NODES nodes, during which cmd_stall is high.
// A new command is taken while the last response still waits on rsp_stall.
// Top level of the pooled linked list engine; depends on pll_pkg and pll_node_mem.
module pooled_linked_list_engine #(
    parameter int NUM_LISTS  = 16,
    parameter int NUM_NODES  = 1024,
    parameter int ITEM_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  pll_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output pll_pkg::rsp_t rsp
);
    import pll_pkg::*;

    localparam int AW  = $clog2(NUM_NODES);
    localparam int LKW = $clog2(NUM_NODES + 1);
    localparam int LW  = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int DW  = $clog2(NUM_LISTS + 1);
    localparam logic [LKW-1:0] NIL      = LKW'(NUM_NODES);
    localparam logic [AW-1:0]  CLR_LAST = AW'(NUM_NODES - 1);

    state_t state_reg, state_next;

    // list heads
    logic [LKW-1:0] hd_first [NUM_LISTS];
    logic [LKW-1:0] hd_last  [NUM_LISTS];
    logic [LKW-1:0] hd_cur   [NUM_LISTS];
    logic [LKW-1:0] hd_cnt   [NUM_LISTS];
    logic           hd_flag  [NUM_LISTS];
    logic           hd_used  [NUM_LISTS];
    logic [LW-1:0]  fh_stack [NUM_LISTS];
    logic [DW-1:0]  fh_depth_reg;
    logic [LKW-1:0] ftop_reg, ftop_next;
    logic [AW-1:0]  clr_reg, clr_next;

    // head write port
    logic           hw_en;
    logic [LW-1:0]  hw_addr;
    logic [LKW-1:0] hw_first, hw_last, hw_cur, hw_cnt;
    logic           hw_flag, hw_used;
    logic           fh_pop, fh_push;
    logic [LW-1:0]  fh_push_val;
    logic [DW-1:0]  fh_dm1;
    logic [LW-1:0]  fh_top;

    // command working copy
    logic [3:0]            op_reg, op_next;
    logic [3:0]            hid_reg, hid_next;
    logic [3:0]            h2id_reg, h2id_next;
    logic [ITEM_WIDTH-1:0] item_reg, item_next;
    logic                  okh_reg, okh_next;
    logic [LKW-1:0]        wf_reg, wf_next, wl_reg, wl_next, wc_reg, wc_next;
    logic [LKW-1:0]        wcnt_reg, wcnt_next;
    logic                  wg_reg, wg_next;
    logic                  wb_reg, wb_next;
    logic [1:0]            st_reg, st_next;
    logic [ITEM_WIDTH-1:0] res_reg, res_next;
    logic [3:0]            nid_reg, nid_next;
    logic [LKW-1:0]        x_reg, x_next, a_reg, a_next, b_reg, b_next;

    logic [LW-1:0]  rsel;
    logic           h2_ok, far_side;
    logic [LKW-1:0] ai, bi;

    // node store ports
    logic [AW-1:0]         rd_addr;
    logic [ITEM_WIDTH-1:0] rd_item;
    logic [LKW-1:0]        rd_next, rd_prev;
    logic                  wi_en, wn_en, wp_en;
    logic [AW-1:0]         wi_addr, wn_addr, wp_addr;
    logic [ITEM_WIDTH-1:0] wi_data;
    logic [LKW-1:0]        wn_data, wp_data;

    logic  rsp_valid_reg, rsp_load;
    rsp_t  rsp_reg;

    pll_node_mem #(
        .NUM_NODES  (NUM_NODES),
        .ITEM_WIDTH (ITEM_WIDTH),
        .AW         (AW),
        .LKW        (LKW)
    ) u_node_mem (
        .clk     (clk),
        .rd_addr (rd_addr),
        .rd_item (rd_item),
        .rd_next (rd_next),
        .rd_prev (rd_prev),
        .wi_en   (wi_en),
        .wi_addr (wi_addr),
        .wi_data (wi_data),
        .wn_en   (wn_en),
        .wn_addr (wn_addr),
        .wn_data (wn_data),
        .wp_en   (wp_en),
        .wp_addr (wp_addr),
        .wp_data (wp_data)
    );

    // head read address: the command's list while idle, the second list after
    assign rsel     = (state_reg == S_IDLE) ? LW'(cmd.list_id) : LW'(h2id_reg);
    assign h2_ok    = (int'(h2id_reg) < NUM_LISTS) && hd_used[rsel] && (h2id_reg != hid_reg);
    assign far_side = (op_reg == OP_NEXT) ? (wg_reg == BEFORE_START) : (wg_reg == BEYOND_END);
    assign fh_dm1   = fh_depth_reg - DW'(1);
    assign fh_top   = fh_stack[fh_dm1[LW-1:0]];

    // insert neighbours, taken from the cursor node when it was read
    always_comb
    begin
        ai = a_reg;
        bi = b_reg;
        if (wc_reg != NIL && op_reg == OP_INS_AFTER)
        begin
            ai = wc_reg;
            bi = rd_next;
        end
        else if (wc_reg != NIL && op_reg == OP_INS_BEFORE)
        begin
            ai = rd_prev;
            bi = wc_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        ftop_next  = ftop_reg;
        op_next    = op_reg;
        hid_next   = hid_reg;
        h2id_next  = h2id_reg;
        item_next  = item_reg;
        okh_next   = okh_reg;
        wf_next    = wf_reg;
        wl_next    = wl_reg;
        wc_next    = wc_reg;
        wcnt_next  = wcnt_reg;
        wg_next    = wg_reg;
        wb_next    = wb_reg;
        st_next    = st_reg;
        res_next   = res_reg;
        nid_next   = nid_reg;
        x_next     = x_reg;
        a_next     = a_reg;
        b_next     = b_reg;

        hw_en       = 1'b0;
        hw_addr     = LW'(hid_reg);
        hw_first    = wf_reg;
        hw_last     = wl_reg;
        hw_cur      = wc_reg;
        hw_cnt      = wcnt_reg;
        hw_flag     = wg_reg;
        hw_used     = 1'b1;
        fh_pop      = 1'b0;
        fh_push     = 1'b0;
        fh_push_val = LW'(hid_reg);

        rd_addr = x_reg[AW-1:0];
        wi_en   = 1'b0;
        wi_addr = x_reg[AW-1:0];
        wi_data = item_reg;
        wn_en   = 1'b0;
        wn_addr = x_reg[AW-1:0];
        wn_data = NIL;
        wp_en   = 1'b0;
        wp_addr = x_reg[AW-1:0];
        wp_data = NIL;

        cmd_stall = (state_reg != S_IDLE);
        rsp_load  = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                wn_en   = 1'b1;
                wn_addr = clr_reg;
                wn_data = (clr_reg == '0) ? NIL : LKW'(clr_reg) - LKW'(1);
                clr_next = clr_reg + AW'(1);
                if (clr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next   = cmd.op;
                    hid_next  = cmd.list_id;
                    h2id_next = cmd.second_list_id;
                    item_next = ITEM_WIDTH'(cmd.item_handle);
                    okh_next  = (int'(cmd.list_id) < NUM_LISTS) && hd_used[rsel];
                    wf_next   = hd_first[rsel];
                    wl_next   = hd_last[rsel];
                    wc_next   = hd_cur[rsel];
                    wcnt_next = hd_cnt[rsel];
                    wg_next   = hd_flag[rsel];
                    wb_next   = 1'b0;
                    st_next   = ST_OK;
                    res_next  = '0;
                    nid_next  = '0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_FIN;
                if (op_reg == OP_CREATE)
                begin
                    if (fh_depth_reg == '0)
                    begin
                        st_next = ST_EXHAUSTED;
                    end
                    else
                    begin
                        fh_pop   = 1'b1;
                        nid_next = 4'(fh_top);
                        hw_en    = 1'b1;
                        hw_addr  = fh_top;
                        hw_first = NIL;
                        hw_last  = NIL;
                        hw_cur   = NIL;
                        hw_cnt   = '0;
                        hw_flag  = BEFORE_START;
                    end
                end
                else if (op_reg > OP_FREE || !okh_reg)
                begin
                    st_next = ST_BOUNDS;
                end
                else
                begin
                    case (op_reg)
                        OP_APPEND, OP_PREPEND, OP_INS_AFTER, OP_INS_BEFORE:
                        begin
                            if (item_reg == '0)
                            begin
                                st_next = ST_NULL_ITEM;
                            end
                            else if (ftop_reg == NIL)
                            begin
                                st_next = ST_EXHAUSTED;
                            end
                            else
                            begin
                                x_next     = ftop_reg;
                                rd_addr    = ftop_reg[AW-1:0];
                                state_next = S_INS1;
                            end
                        end
                        OP_FIRST, OP_LAST:
                        begin
                            x_next     = (op_reg == OP_FIRST) ? wf_reg : wl_reg;
                            state_next = S_TGT;
                        end
                        OP_NEXT, OP_PREV:
                        begin
                            if (wc_reg == NIL)
                            begin
                                if (far_side)
                                begin
                                    x_next = (op_reg == OP_NEXT) ? wf_reg : wl_reg;
                                end
                                else
                                begin
                                    x_next = NIL;
                                end
                                state_next = S_TGT;
                            end
                            else
                            begin
                                rd_addr    = wc_reg[AW-1:0];
                                state_next = S_STEP;
                            end
                        end
                        OP_CURR:
                        begin
                            if (wc_reg == NIL)
                            begin
                                st_next = ST_BOUNDS;
                            end
                            else
                            begin
                                rd_addr    = wc_reg[AW-1:0];
                                state_next = S_ITEM;
                            end
                        end
                        OP_REMOVE, OP_TRIM:
                        begin
                            if ((op_reg == OP_REMOVE ? wc_reg : wl_reg) == NIL)
                            begin
                                st_next = ST_BOUNDS;
                            end
                            else
                            begin
                                x_next     = (op_reg == OP_REMOVE) ? wc_reg : wl_reg;
                                rd_addr    = (op_reg == OP_REMOVE) ? wc_reg[AW-1:0]
                                                                   : wl_reg[AW-1:0];
                                state_next = S_UNL1;
                            end
                        end
                        OP_CONCAT:
                        begin
                            if (!h2_ok)
                            begin
                                st_next = ST_BOUNDS;
                            end
                            else
                            begin
                                if (hd_first[rsel] != NIL)
                                begin
                                    if (wl_reg == NIL)
                                    begin
                                        wf_next = hd_first[rsel];
                                    end
                                    else
                                    begin
                                        wn_en   = 1'b1;
                                        wn_addr = wl_reg[AW-1:0];
                                        wn_data = hd_first[rsel];
                                        wp_en   = 1'b1;
                                        wp_addr = hd_first[rsel][AW-1:0];
                                        wp_data = wl_reg;
                                    end
                                    wl_next   = hd_last[rsel];
                                    wcnt_next = wcnt_reg + hd_cnt[rsel];
                                end
                                // release the second head
                                hw_en       = 1'b1;
                                hw_addr     = rsel;
                                hw_first    = NIL;
                                hw_last     = NIL;
                                hw_cur      = NIL;
                                hw_cnt      = '0;
                                hw_flag     = BEFORE_START;
                                hw_used     = 1'b0;
                                fh_push     = 1'b1;
                                fh_push_val = rsel;
                                wb_next     = 1'b1;
                            end
                        end
                        OP_FREE:
                        begin
                            if (wf_reg == NIL)
                            begin
                                hw_en    = 1'b1;
                                hw_first = NIL;
                                hw_last  = NIL;
                                hw_cur   = NIL;
                                hw_cnt   = '0;
                                hw_flag  = BEFORE_START;
                                hw_used  = 1'b0;
                                fh_push  = 1'b1;
                            end
                            else
                            begin
                                x_next     = wf_reg;
                                rd_addr    = wf_reg[AW-1:0];
                                state_next = S_FREE;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_INS1:
            begin
                // pop the free stack, fetch the cursor node for the inserts
                ftop_next = rd_next;
                if (op_reg == OP_APPEND)
                begin
                    a_next = wl_reg;
                    b_next = NIL;
                end
                else if (op_reg == OP_PREPEND || (wc_reg == NIL && wg_reg == BEFORE_START))
                begin
                    a_next = NIL;
                    b_next = wf_reg;
                end
                else
                begin
                    a_next = wl_reg;
                    b_next = NIL;
                end
                rd_addr    = wc_reg[AW-1:0];
                state_next = S_INS2;
            end
            S_INS2:
            begin
                wi_en      = 1'b1;
                wn_en      = 1'b1;
                wn_data    = bi;
                wp_en      = 1'b1;
                wp_data    = ai;
                a_next     = ai;
                b_next     = bi;
                state_next = S_INS3;
            end
            S_INS3:
            begin
                if (a_reg != NIL)
                begin
                    wn_en   = 1'b1;
                    wn_addr = a_reg[AW-1:0];
                    wn_data = x_reg;
                end
                else
                begin
                    wf_next = x_reg;
                end
                if (b_reg != NIL)
                begin
                    wp_en   = 1'b1;
                    wp_addr = b_reg[AW-1:0];
                    wp_data = x_reg;
                end
                else
                begin
                    wl_next = x_reg;
                end
                wc_next    = x_reg;
                wcnt_next  = wcnt_reg + LKW'(1);
                wb_next    = 1'b1;
                state_next = S_FIN;
            end
            S_STEP:
            begin
                x_next     = (op_reg == OP_NEXT) ? rd_next : rd_prev;
                state_next = S_TGT;
            end
            S_TGT:
            begin
                wc_next = x_reg;
                wb_next = 1'b1;
                if (x_reg == NIL)
                begin
                    st_next = ST_BOUNDS;
                    if (op_reg == OP_NEXT)
                    begin
                        wg_next = BEYOND_END;
                    end
                    else if (op_reg == OP_PREV)
                    begin
                        wg_next = BEFORE_START;
                    end
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_ITEM;
                end
            end
            S_ITEM:
            begin
                res_next   = rd_item;
                state_next = S_FIN;
            end
            S_UNL1:
            begin
                res_next = rd_item;
                a_next   = rd_prev;
                b_next   = rd_next;
                if (rd_prev != NIL)
                begin
                    wn_en   = 1'b1;
                    wn_addr = rd_prev[AW-1:0];
                    wn_data = rd_next;
                end
                else
                begin
                    wf_next = rd_next;
                end
                if (rd_next != NIL)
                begin
                    wp_en   = 1'b1;
                    wp_addr = rd_next[AW-1:0];
                    wp_data = rd_prev;
                end
                else
                begin
                    wl_next = rd_prev;
                end
                state_next = S_UNL2;
            end
            S_UNL2:
            begin
                // give the node back to the pool
                wn_en     = 1'b1;
                wn_data   = ftop_reg;
                wp_en     = 1'b1;
                wp_data   = NIL;
                ftop_next = x_reg;
                wcnt_next = wcnt_reg - LKW'(1);
                wc_next   = (op_reg == OP_REMOVE) ? b_reg : a_reg;
                if (((op_reg == OP_REMOVE) ? b_reg : a_reg) == NIL)
                begin
                    wg_next = BEYOND_END;
                end
                wb_next    = 1'b1;
                state_next = S_FIN;
            end
            S_FREE:
            begin
                wn_en     = 1'b1;
                wn_data   = ftop_reg;
                wp_en     = 1'b1;
                wp_data   = NIL;
                ftop_next = x_reg;
                if (rd_next == NIL)
                begin
                    hw_en      = 1'b1;
                    hw_first   = NIL;
                    hw_last    = NIL;
                    hw_cur     = NIL;
                    hw_cnt     = '0;
                    hw_flag    = BEFORE_START;
                    hw_used    = 1'b0;
                    fh_push    = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    x_next  = rd_next;
                    rd_addr = rd_next[AW-1:0];
                end
            end
            S_FIN:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_load   = 1'b1;
                    hw_en      = wb_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            ftop_reg      <= LKW'(NUM_NODES - 1);
            fh_depth_reg  <= DW'(NUM_LISTS);
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                hd_first[i] <= NIL;
                hd_last[i]  <= NIL;
                hd_cur[i]   <= NIL;
                hd_cnt[i]   <= '0;
                hd_flag[i]  <= BEFORE_START;
                hd_used[i]  <= 1'b0;
                fh_stack[i] <= LW'(i);
            end
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ftop_reg  <= ftop_next;
            if (hw_en)
            begin
                hd_first[hw_addr] <= hw_first;
                hd_last[hw_addr]  <= hw_last;
                hd_cur[hw_addr]   <= hw_cur;
                hd_cnt[hw_addr]   <= hw_cnt;
                hd_flag[hw_addr]  <= hw_flag;
                hd_used[hw_addr]  <= hw_used;
            end
            if (fh_pop)
            begin
                fh_depth_reg <= fh_dm1;
            end
            else if (fh_push && int'(fh_depth_reg) < NUM_LISTS)
            begin
                fh_stack[fh_depth_reg[LW-1:0]] <= fh_push_val;
                fh_depth_reg <= fh_depth_reg + DW'(1);
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        hid_reg  <= hid_next;
        h2id_reg <= h2id_next;
        item_reg <= item_next;
        okh_reg  <= okh_next;
        wf_reg   <= wf_next;
        wl_reg   <= wl_next;
        wc_reg   <= wc_next;
        wcnt_reg <= wcnt_next;
        wg_reg   <= wg_next;
        wb_reg   <= wb_next;
        st_reg   <= st_next;
        res_reg  <= res_next;
        nid_reg  <= nid_next;
        x_reg    <= x_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        if (rsp_load)
        begin
            rsp_reg.status      <= st_reg;
            rsp_reg.result_item <= (st_reg == ST_OK) ? 32'(res_reg) : 32'd0;
            rsp_reg.new_list_id <= nid_reg;
            rsp_reg.item_count  <= (okh_reg && op_reg != OP_CREATE && op_reg != OP_FREE
                                    && op_reg <= OP_FREE) ? 11'(wcnt_reg) : 11'd0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- hw/rtl/pll_node_mem.sv -----
// pll_node_mem: node store of the list engine, item, next link and prev link
// arrays, registered reads from one shared address, a write port per array.
// No package dependencies.
module pll_node_mem #(
    parameter int NUM_NODES  = 1024,
    parameter int ITEM_WIDTH = 32,
    parameter int AW         = $clog2(NUM_NODES),
    parameter int LKW        = $clog2(NUM_NODES + 1)
) (
    input  logic                  clk,
    input  logic [AW-1:0]         rd_addr,
    output logic [ITEM_WIDTH-1:0] rd_item,
    output logic [LKW-1:0]        rd_next,
    output logic [LKW-1:0]        rd_prev,
    input  logic                  wi_en,
    input  logic [AW-1:0]         wi_addr,
    input  logic [ITEM_WIDTH-1:0] wi_data,
    input  logic                  wn_en,
    input  logic [AW-1:0]         wn_addr,
    input  logic [LKW-1:0]        wn_data,
    input  logic                  wp_en,
    input  logic [AW-1:0]         wp_addr,
    input  logic [LKW-1:0]        wp_data
);

    logic [ITEM_WIDTH-1:0] item_mem [NUM_NODES];
    logic [LKW-1:0]        next_mem [NUM_NODES];
    logic [LKW-1:0]        prev_mem [NUM_NODES];

    always_ff @(posedge clk)
    begin
        if (wi_en)
        begin
            item_mem[wi_addr] <= wi_data;
        end
        rd_item <= item_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wn_en)
        begin
            next_mem[wn_addr] <= wn_data;
        end
        rd_next <= next_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wp_en)
        begin
            prev_mem[wp_addr] <= wp_data;
        end
        rd_prev <= prev_mem[rd_addr];
    end

endmodule
